// ===== sv/pcid_tag_and_shootdown_manager_unit_macros.svh =====
// Assertion macros used by the top-level RTL file of the PCID tag and shootdown manager.
`ifndef PCID_TAG_AND_SHOOTDOWN_MANAGER_UNIT_MACROS_SVH
`define PCID_TAG_AND_SHOOTDOWN_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PTSM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PTSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ptsm_pkg.sv =====
// Package with the types, constants and helper functions of the PCID tag and shootdown manager.
`default_nettype none

package ptsm_pkg;

    // Default sizes handed to the top level as parameters.
    localparam int MAX_CPUS_DEF   = 8;
    localparam int TAG_COUNT_DEF  = 4096;
    localparam int PAGE_LIMIT_DEF = 32;

    // Fixed widths and constants of the interface.
    localparam int ROOT_W      = 40;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_SIZE   = 4096;
    localparam int NOFLUSH_BIT = 63;
    localparam int PAGE_SAT    = 63;
    localparam int MOD_DIGITS  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [63:0] USER_LIMIT_RST = 64'h0000_8000_0000_0000;

    // Commands carried in an input item.
    typedef enum logic [1:0] {
        CMD_ACTIVATE   = 2'd0,
        CMD_INVALIDATE = 2'd1,
        CMD_POLL       = 2'd2
    } t_cmd;

    // Local flush actions.
    typedef enum logic [2:0] {
        FL_NONE    = 3'd0,
        FL_ALL     = 3'd1,
        FL_PAGE    = 3'd2,
        FL_CONTEXT = 3'd3,
        FL_RELOAD  = 3'd4
    } t_flush;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PCID_EN    = 2'd0,
        CFG_INVPCID_EN = 2'd1,
        CFG_USER_LIMIT = 2'd2,
        CFG_CPUS       = 2'd3
    } t_cfg_reg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [2:0]        cpu_index;
        logic [ROOT_W-1:0] root_frame;
        logic [63:0]       virt_address;
        logic [31:0]       length_bytes;
        logic [63:0]       loaded_cr3;
        logic [7:0]        online_mask;
    } t_in_item;

    typedef struct packed {
        logic        write_cr3;
        logic [63:0] cr3_value;
        logic [2:0]  flush_action;
        logic [5:0]  page_count;
        logic [11:0] context_tag;
        logic [7:0]  target_mask;
        logic        served;
    } t_out_item;

    // Outcome of the local flush decision.
    typedef struct packed {
        t_flush      action;
        logic [5:0]  pages;
        logic [11:0] ctx;
        logic [63:0] cr3;
    } t_local;

    // Decides how a processor flushes its own TLB for a range.
    function automatic t_local local_action(
        input logic [ROOT_W-1:0] root,
        input logic [63:0]       addr,
        input logic [31:0]       len,
        input logic [63:0]       cur,
        input logic [63:0]       limit,
        input logic [31:0]       len_limit,
        input logic              pcid_en,
        input logic              invpcid_en
    );
        t_local      res;
        logic [32:0] sum;
        logic [20:0] pages;
        res   = '0;
        res.action = FL_NONE;
        sum   = {1'b0, len} + 33'(PAGE_SIZE - 1);
        pages = sum[32:PAGE_SHIFT];
        if (addr >= limit) begin
            res.action = FL_ALL;
        end else if (cur[63:PAGE_SHIFT] != {{(64-PAGE_SHIFT-ROOT_W){1'b0}}, root}) begin
            res.action = FL_NONE;
        end else if (len != 32'd0 && len <= len_limit) begin
            res.action = FL_PAGE;
            res.pages  = (pages > 21'(PAGE_SAT)) ? 6'(PAGE_SAT) : pages[5:0];
        end else if (invpcid_en) begin
            res.action = FL_CONTEXT;
            res.ctx    = pcid_en ? cur[11:0] : 12'd0;
        end else begin
            res.action = FL_RELOAD;
            res.cr3    = cur;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pcid_tag_and_shootdown_manager_unit.sv =====
// Top level of the PCID tag cache and TLB shootdown manager.
// Poll and unknown commands go straight to the result register; activate waits for the
// remainder unit, then reads the tag with PCIDs; invalidate waits for the remainder unit,
// then scans each processor up to the configured count. One item at a time: ready
// returns the cycle after the result loads, which waits while an earlier one is held.
// Reset clears every tag table entry, one a cycle, first.
`default_nettype none
`include "pcid_tag_and_shootdown_manager_unit_macros.svh"

module pcid_tag_and_shootdown_manager_unit #(
    parameter int MAX_CPUS   = ptsm_pkg::MAX_CPUS_DEF,
    parameter int TAG_COUNT  = ptsm_pkg::TAG_COUNT_DEF,
    parameter int PAGE_LIMIT = ptsm_pkg::PAGE_LIMIT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire ptsm_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output ptsm_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ptsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ptsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ptsm_pkg::*;

    localparam int TIW   = $clog2(TAG_COUNT);
    localparam int CW    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int AW    = CW + TIW;
    localparam int DEPTH = 1 << AW;
    localparam int CNTW  = $clog2(MAX_CPUS + 1);
    localparam logic [31:0] LEN_LIMIT = 32'(PAGE_LIMIT * PAGE_SIZE);

    // Configuration registers.
    logic              r_cfg_pcid;
    logic              r_cfg_invpcid;
    logic [63:0]       r_cfg_limit;
    logic [3:0]        r_cfg_cpus;

    // Sequencer and item registers.
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    t_in_item          r_in;
    logic [2:0]        r_cpu;
    logic [2:0]        cpu_mod;
    logic [TIW-1:0]    r_pcid, n_pcid;
    logic              r_kernel, n_kernel;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]     r_chk_idx, n_chk_idx;
    logic              r_chk_valid, n_chk_valid;
    logic [7:0]        r_targets, n_targets;

    // Per-processor active roots and the pending shootdown record.
    logic [ROOT_W-1:0] r_active_root [MAX_CPUS];
    logic [ROOT_W-1:0] r_pend_root;
    logic [63:0]       r_pend_addr;
    logic [31:0]       r_pend_len;
    logic [TIW-1:0]    r_pend_pcid;
    logic [7:0]        r_pend_mask, n_pend_mask;

    // Output register.
    logic              r_out_valid;
    t_out_item         r_out_data;

    // Control signals from the sequencer.
    logic              in_accept;
    logic              mod_start;
    logic              mod_done;
    logic [TIW-1:0]    mod_rem;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ROOT_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [ROOT_W-1:0] ram_rdata;
    logic [CW-1:0]     ar_idx;
    logic              ar_match;
    logic              ar_we;
    logic              pend_we;
    logic              out_load;
    t_out_item         out_item;
    logic              scan_go;
    logic [7:0]        scan_sel;
    logic [7:0]        cpu_onehot;
    logic              is_poll;
    t_local            la;

    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Issuing processor reduced modulo the processor count.
    always_comb begin
        int cpu_v;
        cpu_v = int'(i_in_data.cpu_index);
        for (int k = 0; k < 8; k++) begin
            if (cpu_v >= MAX_CPUS) begin
                cpu_v = cpu_v - MAX_CPUS;
            end
        end
        cpu_mod = 3'(cpu_v);
    end

    // Scan position decode and the active root compare port.
    assign scan_go    = (32'(r_cnt) < 32'(r_cfg_cpus)) && (32'(r_cnt) < MAX_CPUS);
    assign cpu_onehot = 8'd1 << r_cpu;
    assign ar_idx     = (r_state == ST_SCAN && scan_go) ? r_cnt[CW-1:0] : CW'(r_cpu);
    assign ar_match   = (r_active_root[ar_idx] == r_in.root_frame);

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            scan_sel[j] = (j < MAX_CPUS) && (r_cnt == CNTW'(j));
        end
    end

    // Local flush decision, on the pending record for a poll.
    assign is_poll = (r_in.cmd == CMD_POLL);
    assign la = local_action(is_poll ? r_pend_root : r_in.root_frame,
                             is_poll ? r_pend_addr : r_in.virt_address,
                             is_poll ? r_pend_len  : r_in.length_bytes,
                             r_in.loaded_cr3, r_cfg_limit, LEN_LIMIT,
                             r_cfg_pcid, r_cfg_invpcid);

    // Next state and sequencer outputs.
    always_comb begin
        logic [63:0] value;
        logic        wr;
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_pcid      = r_pcid;
        n_kernel    = r_kernel;
        n_cnt       = r_cnt;
        n_chk_idx   = r_chk_idx;
        n_chk_valid = r_chk_valid;
        n_targets   = r_targets;
        n_pend_mask = r_pend_mask;
        o_in_ready  = 1'b0;
        mod_start   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = {CW'(r_cpu), r_pcid};
        ram_wdata   = r_in.root_frame;
        ram_raddr   = {CW'(r_cpu), r_pcid};
        ar_we       = 1'b0;
        pend_we     = 1'b0;
        out_load    = 1'b0;
        out_item    = '0;
        value       = '0;
        wr          = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_data.cmd)
                        CMD_ACTIVATE, CMD_INVALIDATE: begin
                            mod_start = 1'b1;
                            n_state   = ST_MOD;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_pcid      = mod_rem;
                    n_kernel    = (r_in.virt_address >= r_cfg_limit);
                    n_cnt       = '0;
                    n_targets   = '0;
                    n_chk_valid = 1'b0;
                    if (r_in.cmd == CMD_INVALIDATE) begin
                        n_state = ST_SCAN;
                    end else if (r_cfg_pcid) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // Check the entry read in the previous cycle and clear a match.
                if (r_chk_valid && !r_kernel && r_cfg_pcid &&
                    ram_rdata == r_in.root_frame) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_chk_idx, r_pcid};
                    ram_wdata = '0;
                end
                if (scan_go) begin
                    ram_raddr   = {r_cnt[CW-1:0], r_pcid};
                    n_chk_idx   = r_cnt[CW-1:0];
                    n_chk_valid = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_kernel || ar_match) begin
                        n_targets = r_targets | (scan_sel & r_in.online_mask & ~cpu_onehot);
                    end
                end else begin
                    n_chk_valid = 1'b0;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                    case (r_in.cmd)
                        CMD_ACTIVATE: begin
                            ar_we = 1'b1;
                            value = {{(64-ROOT_W-PAGE_SHIFT){1'b0}}, r_in.root_frame,
                                     {PAGE_SHIFT{1'b0}}};
                            if (r_cfg_pcid) begin
                                value = value | 64'(r_pcid);
                                if (ram_rdata == r_in.root_frame) begin
                                    wr = (r_in.loaded_cr3 != value);
                                    if (wr) begin
                                        value[NOFLUSH_BIT] = 1'b1;
                                    end
                                end else begin
                                    ram_we = 1'b1;
                                    wr     = 1'b1;
                                end
                            end else begin
                                wr = (r_in.loaded_cr3 != value);
                            end
                            out_item.write_cr3 = wr;
                            out_item.cr3_value = value;
                        end
                        CMD_INVALIDATE: begin
                            out_item.cr3_value    = la.cr3;
                            out_item.flush_action = la.action;
                            out_item.page_count   = la.pages;
                            out_item.context_tag  = la.ctx;
                            out_item.target_mask  = r_targets;
                            if (r_targets != 8'd0) begin
                                pend_we     = 1'b1;
                                n_pend_mask = r_targets;
                            end
                            if (!r_kernel && r_cfg_pcid && ar_match) begin
                                ram_we = 1'b1;
                            end
                        end
                        CMD_POLL: begin
                            if (r_pend_mask[r_cpu]) begin
                                n_pend_mask           = r_pend_mask & ~cpu_onehot;
                                out_item.cr3_value    = la.cr3;
                                out_item.flush_action = la.action;
                                out_item.page_count   = la.pages;
                                out_item.context_tag  = la.ctx;
                                out_item.target_mask  = n_pend_mask;
                                out_item.served       = 1'b1;
                                if (r_cfg_pcid && r_pend_addr < r_cfg_limit &&
                                    r_in.loaded_cr3[63:PAGE_SHIFT] ==
                                    {{(64-PAGE_SHIFT-ROOT_W){1'b0}}, r_pend_root}) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = {CW'(r_cpu), r_pend_pcid};
                                    ram_wdata = r_pend_root;
                                end
                            end
                        end
                        default: begin
                            out_item = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State register and other control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_chk_valid <= 1'b0;
            r_pend_mask <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_CPUS; i++) begin
                r_active_root[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_chk_valid <= n_chk_valid;
            r_pend_mask <= n_pend_mask;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ar_we) begin
                r_active_root[CW'(r_cpu)] <= r_in.root_frame;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pcid    <= 1'b0;
            r_cfg_invpcid <= 1'b0;
            r_cfg_limit   <= USER_LIMIT_RST;
            r_cfg_cpus    <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PCID_EN:    r_cfg_pcid    <= i_cfg_data[0];
                CFG_INVPCID_EN: r_cfg_invpcid <= i_cfg_data[0];
                CFG_USER_LIMIT: r_cfg_limit   <= i_cfg_data;
                CFG_CPUS:       r_cfg_cpus    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Item payload, scan working registers and the pending record.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in  <= i_in_data;
            r_cpu <= cpu_mod;
        end
        r_pcid    <= n_pcid;
        r_kernel  <= n_kernel;
        r_cnt     <= n_cnt;
        r_chk_idx <= n_chk_idx;
        r_targets <= n_targets;
        if (pend_we) begin
            r_pend_root <= r_in.root_frame;
            r_pend_addr <= r_in.virt_address;
            r_pend_len  <= r_in.length_bytes;
            r_pend_pcid <= r_pcid;
        end
        if (out_load) begin
            r_out_data <= out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Root frame remainder unit.
    ptsm_mod_unit #(
        .TAG_COUNT (TAG_COUNT)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_in_data.root_frame),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Tag table, one entry per processor and PCID.
    ptsm_ram #(
        .WIDTH (ROOT_W),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // Checks on the sequencer.
    `PTSM_ASSERT_IMPL(a_clear_quiet, r_state == ST_CLEAR, !o_out_valid, "result during clearing pass")
    `PTSM_ASSERT_NEXT(a_one_item, in_accept, !o_in_ready, "second transfer taken while busy")
    `PTSM_ASSERT_IMPL(a_mod_done, mod_done, r_state == ST_MOD, "remainder finished outside wait")

endmodule

`default_nettype wire

// ===== sv/ptsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ptsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/ptsm_mod_unit.sv =====
// Remainder unit that reduces a root frame number modulo the tag count.
`default_nettype none

module ptsm_mod_unit #(
    parameter int TAG_COUNT = ptsm_pkg::TAG_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ptsm_pkg::ROOT_W-1:0]   i_value,
    output logic                               o_done,
    output logic      [$clog2(TAG_COUNT)-1:0]  o_rem
);
    import ptsm_pkg::*;

    localparam int  TIW  = $clog2(TAG_COUNT);
    localparam bit  POW2 = ((TAG_COUNT & (TAG_COUNT - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            logic           r_done;
            logic [TIW-1:0] r_rem;

            // A power of two needs only the low bits of the frame.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_value[TIW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_iter
            localparam int RW    = TIW + 1;
            localparam int STEPS = ROOT_W / MOD_DIGITS;
            localparam int SCW   = $clog2(STEPS + 1);

            logic              r_busy;
            logic              r_done;
            logic [SCW-1:0]    r_step;
            logic [ROOT_W-1:0] r_shift;
            logic [TIW-1:0]    r_rem;
            logic [ROOT_W-1:0] n_shift;
            logic [TIW-1:0]    n_rem;

            // MOD_DIGITS bits per step, most significant first, each with one
            // compare and subtract.
            always_comb begin
                logic [RW-1:0]     rem_v;
                logic [ROOT_W-1:0] sh_v;
                rem_v = {1'b0, r_rem};
                sh_v  = r_shift;
                for (int k = 0; k < MOD_DIGITS; k++) begin
                    rem_v = {rem_v[RW-2:0], sh_v[ROOT_W-1]};
                    sh_v  = {sh_v[ROOT_W-2:0], 1'b0};
                    if (rem_v >= RW'(TAG_COUNT)) begin
                        rem_v = rem_v - RW'(TAG_COUNT);
                    end
                end
                n_rem   = rem_v[TIW-1:0];
                n_shift = sh_v;
            end

            // Step counter and completion pulse.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_step <= '0;
                    end else if (r_busy) begin
                        r_step <= r_step + 1'b1;
                        if (r_step == SCW'(STEPS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_shift <= i_value;
                    r_rem   <= '0;
                end else if (r_busy) begin
                    r_shift <= n_shift;
                    r_rem   <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire
